/* rtl/cosine_similarity_unit_assert.svh */
// Assertion macros shared by the cosine similarity unit modules.
`ifndef COSINE_SIMILARITY_UNIT_ASSERT_SVH
`define COSINE_SIMILARITY_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cosine similarity unit: check failed");

// The consequent must hold in the cycle after the antecedent.
`define CSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cosine similarity unit: check failed");

`endif

/* rtl/csu_pkg.sv */
// Shared types and constants of the cosine similarity unit.
package csu_pkg;

    // Element and result widths.
    localparam int ELEM_W = 16;
    localparam int SIM_W  = 16;

    // Accumulator width and the limits that the accumulators saturate at.
    localparam int ACC_W = 44;
    localparam logic signed [ACC_W-1:0] DOT_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] DOT_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [ACC_W-1:0] NORM_MAX = {ACC_W{1'b1}};

    // Shared multiplier works on halves of an accumulator value.
    localparam int HALF_W = ACC_W / 2;
    localparam int PROD_W = 2 * ACC_W;

    // Square root recurrence: 16 result bits, 122-bit remainder datapath.
    localparam int ROOT_BITS = 16;
    localparam int CNT_W     = 4;
    localparam int ROOT_W    = 122;
    localparam int L_SHIFT   = 32;
    localparam int V_SHIFT   = 2 * (ROOT_BITS - 1);

    // Largest positive similarity.
    localparam logic [SIM_W-1:0] SIM_MAX = {1'b0, {(SIM_W-1){1'b1}}};

    // Depth of the queue between front and back end.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    // Finished accumulator set of one vector pair.
    typedef struct packed {
        logic signed [ACC_W-1:0] dot;
        logic [ACC_W-1:0]        norm_a;
        logic [ACC_W-1:0]        norm_b;
    } acc_set_t;

    // Back end sequencer states.
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL_SQ,
        BK_MUL_NN,
        BK_ROOT,
        BK_OUT
    } bk_state_t;

endpackage

/* rtl/cosine_similarity_unit.sv */
// Top level of the streaming cosine similarity unit.
//
//   port group  dir  payload                                 ends item
//   s_*         in   tdata: a_elem[15:0] b_elem[31:16]       tlast = last_elem
//   m_*         out  tdata: similarity[15:0], tuser: degen   one item per vector
//
// The front end takes one element pair per cycle while s_tready is high; the vector totals move
// through a two-entry queue to the back end.
// The back end takes the totals, forms the squared dot product and then the
// norm product on a shared 22x22 multiplier, runs 16 square-root steps and
// loads the result register; a vector with a zero norm skips the arithmetic.
// Vectors that outpace the back end fill the queue, and s_tready then
// drops until an entry frees. Reset is synchronous on aresetn, active low.
module cosine_similarity_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] a_elem, [31:16] b_elem
    input  logic        s_tlast,   // last_elem
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] similarity
    output logic        m_tuser    // degenerate
);

    csu_pkg::acc_set_t push_data;
    csu_pkg::acc_set_t pop_data;
    logic              q_push;
    logic              q_full;
    logic              q_valid;
    logic              q_pop;

    // Accumulation of the element stream.
    csu_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (push_data)
    );

    // Decoupling queue.
    csu_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (push_data),
        .full    (q_full),
        .valid   (q_valid),
        .rdata   (pop_data),
        .pop     (q_pop)
    );

    // Similarity computation and result register.
    csu_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_data   (pop_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

/* rtl/csu_front.sv */
// Front end: accepts element pairs and accumulates dot product and norms.
`include "cosine_similarity_unit_assert.svh"

module csu_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [31:0]         s_tdata,   // [15:0] a_elem, [31:16] b_elem
    input  logic                s_tlast,   // last_elem
    input  logic                q_full,
    output logic                q_push,
    output csu_pkg::acc_set_t   q_data
);

    logic signed [csu_pkg::ACC_W-1:0] dot_reg, dot_next;
    logic [csu_pkg::ACC_W-1:0]        na_reg, na_next;
    logic [csu_pkg::ACC_W-1:0]        nb_reg, nb_next;

    logic signed [csu_pkg::ELEM_W-1:0] a_elem, b_elem;
    logic signed [2*csu_pkg::ELEM_W-1:0] prod_ab, prod_aa, prod_bb;
    logic [csu_pkg::ACC_W:0]           dot_sum, na_sum, nb_sum;
    logic signed [csu_pkg::ACC_W-1:0]  dot_sat;
    logic [csu_pkg::ACC_W-1:0]         na_sat, nb_sat;
    logic                              accept;

    // An item is taken whenever the queue can hold a finished vector.
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    assign a_elem = s_tdata[csu_pkg::ELEM_W-1:0];
    assign b_elem = s_tdata[2*csu_pkg::ELEM_W-1:csu_pkg::ELEM_W];

    // Element products.
    assign prod_ab = a_elem * b_elem;
    assign prod_aa = a_elem * a_elem;
    assign prod_bb = b_elem * b_elem;

    // Wide sums with one guard bit.
    assign dot_sum = {dot_reg[csu_pkg::ACC_W-1], dot_reg}
                   + {{(csu_pkg::ACC_W+1-2*csu_pkg::ELEM_W){prod_ab[2*csu_pkg::ELEM_W-1]}},
                      prod_ab};
    assign na_sum  = {1'b0, na_reg}
                   + {{(csu_pkg::ACC_W+1-2*csu_pkg::ELEM_W){1'b0}}, prod_aa};
    assign nb_sum  = {1'b0, nb_reg}
                   + {{(csu_pkg::ACC_W+1-2*csu_pkg::ELEM_W){1'b0}}, prod_bb};

    // Saturate to the accumulator range.
    always_comb begin
        if (dot_sum[csu_pkg::ACC_W] != dot_sum[csu_pkg::ACC_W-1]) begin
            dot_sat = dot_sum[csu_pkg::ACC_W] ? csu_pkg::DOT_MIN : csu_pkg::DOT_MAX;
        end else begin
            dot_sat = dot_sum[csu_pkg::ACC_W-1:0];
        end
        na_sat = na_sum[csu_pkg::ACC_W] ? csu_pkg::NORM_MAX : na_sum[csu_pkg::ACC_W-1:0];
        nb_sat = nb_sum[csu_pkg::ACC_W] ? csu_pkg::NORM_MAX : nb_sum[csu_pkg::ACC_W-1:0];
    end

    // The last item hands the totals to the queue and clears the accumulators.
    assign q_push        = accept && s_tlast;
    assign q_data.dot    = dot_sat;
    assign q_data.norm_a = na_sat;
    assign q_data.norm_b = nb_sat;

    always_comb begin
        dot_next = dot_reg;
        na_next  = na_reg;
        nb_next  = nb_reg;
        if (accept) begin
            if (s_tlast) begin
                dot_next = '0;
                na_next  = '0;
                nb_next  = '0;
            end else begin
                dot_next = dot_sat;
                na_next  = na_sat;
                nb_next  = nb_sat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_reg <= '0;
            na_reg  <= '0;
            nb_reg  <= '0;
        end else begin
            dot_reg <= dot_next;
            na_reg  <= na_next;
            nb_reg  <= nb_next;
        end
    end

    // A vector ends with all accumulators cleared.
    `CSU_ASSERT_NEXT(a_front_clear, aclk, aresetn, q_push, (dot_reg == '0) && (na_reg == '0) && (nb_reg == '0))
    // A norm can only be zero while every product so far was zero.
    `CSU_ASSERT_NOW(a_front_zero_norm, aclk, aresetn, (na_reg == '0) || (nb_reg == '0), dot_reg == '0)

endmodule

/* rtl/csu_queue.sv */
// Short queue of finished accumulator sets between front and back end.
`include "cosine_similarity_unit_assert.svh"

module csu_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  csu_pkg::acc_set_t wdata,
    output logic              full,
    output logic              valid,
    output csu_pkg::acc_set_t rdata,
    input  logic              pop
);

    csu_pkg::acc_set_t            entry_reg [csu_pkg::Q_DEPTH];
    logic [csu_pkg::Q_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [csu_pkg::Q_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [csu_pkg::Q_PTR_W:0]    count_reg, count_next;

    assign full  = (count_reg == (csu_pkg::Q_PTR_W+1)'(csu_pkg::Q_DEPTH));
    assign valid = (count_reg != '0);
    assign rdata = entry_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

    `CSU_ASSERT_NOW(a_queue_no_overrun, aclk, aresetn, push, !full || pop)
    `CSU_ASSERT_NOW(a_queue_no_underrun, aclk, aresetn, pop, valid)

endmodule

/* rtl/csu_back.sv */
// Back end: squares, norm product, square-root recurrence and result register.
`include "cosine_similarity_unit_assert.svh"

module csu_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  csu_pkg::acc_set_t q_data,
    output logic              q_pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,   // [15:0] similarity
    output logic              m_tuser    // degenerate
);

    csu_pkg::bk_state_t state_reg, state_next;

    logic [csu_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [csu_pkg::ACC_W-1:0]     mag_reg, mag_next;
    logic [csu_pkg::ACC_W-1:0]     na_reg, na_next;
    logic [csu_pkg::ACC_W-1:0]     nb_reg, nb_next;
    logic                          neg_reg, neg_next;
    logic                          degen_reg, degen_next;
    logic [csu_pkg::PROD_W-1:0]    acc_reg, acc_next;
    logic [csu_pkg::ROOT_W-1:0]    r_reg, r_next;
    logic [csu_pkg::ROOT_W-1:0]    u_reg, u_next;
    logic [csu_pkg::ROOT_W-1:0]    v_reg, v_next;
    logic [csu_pkg::ROOT_BITS-1:0] m_reg, m_next;
    logic [csu_pkg::SIM_W-1:0]     sim_reg, sim_next;
    logic                          ovalid_reg, ovalid_next;
    logic                          uflag_reg, uflag_next;

    logic                          in_degen;
    logic                          out_free;
    logic                          load_out;
    logic [csu_pkg::ACC_W-1:0]     op_x, op_y;
    logic [csu_pkg::HALF_W-1:0]    mul_x, mul_y;
    logic [csu_pkg::ACC_W-1:0]     pp;
    logic [csu_pkg::PROD_W-1:0]    pp_shift;
    logic [csu_pkg::PROD_W-1:0]    acc_sum;
    logic [csu_pkg::ROOT_W-1:0]    root_d;
    logic                          root_take;
    logic [csu_pkg::ROOT_BITS:0]   k_val;
    logic [csu_pkg::SIM_W-1:0]     sim_calc;

    assign in_degen = (q_data.norm_a == '0) || (q_data.norm_b == '0);
    assign out_free = !ovalid_reg || m_tready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            csu_pkg::BK_IDLE: begin
                if (q_valid) begin
                    state_next = in_degen ? csu_pkg::BK_OUT : csu_pkg::BK_MUL_SQ;
                end
            end
            csu_pkg::BK_MUL_SQ: begin
                if (cnt_reg[1:0] == 2'b11) begin
                    state_next = csu_pkg::BK_MUL_NN;
                end
            end
            csu_pkg::BK_MUL_NN: begin
                if (cnt_reg[1:0] == 2'b11) begin
                    state_next = csu_pkg::BK_ROOT;
                end
            end
            csu_pkg::BK_ROOT: begin
                if (cnt_reg == '0) begin
                    state_next = csu_pkg::BK_OUT;
                end
            end
            csu_pkg::BK_OUT: begin
                if (out_free) begin
                    state_next = csu_pkg::BK_IDLE;
                end
            end
            default: state_next = csu_pkg::BK_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        q_pop    = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            csu_pkg::BK_IDLE: q_pop    = q_valid;
            csu_pkg::BK_OUT:  load_out = out_free;
            default: begin
                q_pop    = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    // Shared 22x22 multiplier: four partial products per 44x44 product.
    assign op_x  = (state_reg == csu_pkg::BK_MUL_NN) ? na_reg : mag_reg;
    assign op_y  = (state_reg == csu_pkg::BK_MUL_NN) ? nb_reg : mag_reg;
    assign mul_x = cnt_reg[0] ? op_x[csu_pkg::ACC_W-1:csu_pkg::HALF_W]
                              : op_x[csu_pkg::HALF_W-1:0];
    assign mul_y = cnt_reg[1] ? op_y[csu_pkg::ACC_W-1:csu_pkg::HALF_W]
                              : op_y[csu_pkg::HALF_W-1:0];
    assign pp    = mul_x * mul_y;

    always_comb begin
        unique case (cnt_reg[1:0])
            2'b00:        pp_shift = {{csu_pkg::ACC_W{1'b0}}, pp};
            2'b01, 2'b10: pp_shift = {{csu_pkg::HALF_W{1'b0}}, pp, {csu_pkg::HALF_W{1'b0}}};
            default:      pp_shift = {pp, {csu_pkg::ACC_W{1'b0}}};
        endcase
    end

    assign acc_sum = acc_reg + pp_shift;

    // One result bit per step: accept it when the remainder covers the increment.
    assign root_d    = u_reg + v_reg;
    assign root_take = (r_reg >= root_d);

    // Rounded magnitude from the floor root, then sign and saturation.
    assign k_val = ({1'b0, m_reg} + (csu_pkg::ROOT_BITS+1)'(1)) >> 1;

    always_comb begin
        if (neg_reg) begin
            sim_calc = csu_pkg::SIM_W'(-k_val);
        end else if (k_val > {1'b0, csu_pkg::SIM_MAX}) begin
            sim_calc = csu_pkg::SIM_MAX;
        end else begin
            sim_calc = k_val[csu_pkg::SIM_W-1:0];
        end
    end

    // Datapath register updates.
    always_comb begin
        cnt_next   = cnt_reg;
        mag_next   = mag_reg;
        na_next    = na_reg;
        nb_next    = nb_reg;
        neg_next   = neg_reg;
        degen_next = degen_reg;
        acc_next   = acc_reg;
        r_next     = r_reg;
        u_next     = u_reg;
        v_next     = v_reg;
        m_next     = m_reg;
        unique case (state_reg)
            csu_pkg::BK_IDLE: begin
                if (q_valid) begin
                    neg_next   = q_data.dot[csu_pkg::ACC_W-1];
                    mag_next   = q_data.dot[csu_pkg::ACC_W-1] ? -q_data.dot : q_data.dot;
                    na_next    = q_data.norm_a;
                    nb_next    = q_data.norm_b;
                    degen_next = in_degen;
                    acc_next   = '0;
                    cnt_next   = '0;
                end
            end
            csu_pkg::BK_MUL_SQ: begin
                if (cnt_reg[1:0] == 2'b11) begin
                    // Squared dot product scaled by 2^32 seeds the remainder.
                    r_next   = {{(csu_pkg::ROOT_W-csu_pkg::PROD_W-csu_pkg::L_SHIFT){1'b0}},
                                acc_sum, {csu_pkg::L_SHIFT{1'b0}}};
                    acc_next = '0;
                    cnt_next = '0;
                end else begin
                    acc_next = acc_sum;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            csu_pkg::BK_MUL_NN: begin
                if (cnt_reg[1:0] == 2'b11) begin
                    // Norm product aligned to the top result bit.
                    v_next   = {{(csu_pkg::ROOT_W-csu_pkg::PROD_W-csu_pkg::V_SHIFT){1'b0}},
                                acc_sum, {csu_pkg::V_SHIFT{1'b0}}};
                    u_next   = '0;
                    m_next   = '0;
                    acc_next = '0;
                    cnt_next = csu_pkg::CNT_W'(csu_pkg::ROOT_BITS - 1);
                end else begin
                    acc_next = acc_sum;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            csu_pkg::BK_ROOT: begin
                if (root_take) begin
                    r_next = r_reg - root_d;
                    u_next = (u_reg >> 1) + v_reg;
                    m_next = m_reg | (csu_pkg::ROOT_BITS'(1) << cnt_reg);
                end else begin
                    u_next = u_reg >> 1;
                end
                v_next   = v_reg >> 2;
                cnt_next = cnt_reg - 1'b1;
            end
            csu_pkg::BK_OUT: begin
                cnt_next = cnt_reg;
            end
            default: begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // Result register: holds an item until the sink takes it.
    always_comb begin
        ovalid_next = ovalid_reg;
        sim_next    = sim_reg;
        uflag_next  = uflag_reg;
        if (ovalid_reg && m_tready) begin
            ovalid_next = 1'b0;
        end
        if (load_out) begin
            ovalid_next = 1'b1;
            sim_next    = degen_reg ? '0 : sim_calc;
            uflag_next  = degen_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= csu_pkg::BK_IDLE;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg   <= cnt_next;
        mag_reg   <= mag_next;
        na_reg    <= na_next;
        nb_reg    <= nb_next;
        neg_reg   <= neg_next;
        degen_reg <= degen_next;
        acc_reg   <= acc_next;
        r_reg     <= r_next;
        u_reg     <= u_next;
        v_reg     <= v_next;
        m_reg     <= m_next;
        sim_reg   <= sim_next;
        uflag_reg <= uflag_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = sim_reg;
    assign m_tuser  = uflag_reg;

    // A degenerate item always carries a zero similarity.
    `CSU_ASSERT_NOW(a_back_degen_zero, aclk, aresetn, ovalid_reg && uflag_reg, sim_reg == '0)
    // Root bits at and below the current step are still clear.
    `CSU_ASSERT_NOW(a_back_root_order, aclk, aresetn, state_reg == csu_pkg::BK_ROOT, (m_reg << (4'd15 - cnt_reg)) == 16'd0)

endmodule
